FILE: rtl/core/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg
// Shared constants and a helper function for the coprime-stride tile dispatcher.
// ----------------------------------------------------------------------------
package csd_pkg;

    localparam int unsigned SEED_W     = 32;
    localparam int unsigned TILE_W     = 16;
    localparam int unsigned STEP_W     = $clog2(SEED_W + 1);
    localparam logic [SEED_W-1:0] SEED_RESET = 32'hCAFE_BABE;

    localparam int unsigned XS_SHIFT_A = 13;
    localparam int unsigned XS_SHIFT_B = 17;
    localparam int unsigned XS_SHIFT_C = 5;

    // Advance the seed by one xorshift32 step.
    function automatic logic [SEED_W-1:0] xorshift_next(input logic [SEED_W-1:0] x);
        logic [SEED_W-1:0] v;
        v = x;
        v = v ^ (v << XS_SHIFT_A);
        v = v ^ (v >> XS_SHIFT_B);
        v = v ^ (v << XS_SHIFT_C);
        return v;
    endfunction

endpackage

FILE: rtl/core/csd_modadd.sv
// ----------------------------------------------------------------------------
// csd_modadd
// Modular adder: (a + b + cin) mod m, for a and b already below m.
// ----------------------------------------------------------------------------
module csd_modadd #(
    parameter int unsigned WIDTH = 16
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             cin,
    input  logic [WIDTH-1:0] modulus,
    output logic [WIDTH-1:0] result
);

    logic [WIDTH:0] sum;
    logic [WIDTH:0] diff;

    // Add, then fold back once: the sum stays below twice the modulus
    assign sum    = {1'b0, a} + {1'b0, b} + {{WIDTH{1'b0}}, cin};
    assign diff   = sum - {1'b0, modulus};
    assign result = (sum >= {1'b0, modulus}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];

endmodule

FILE: rtl/core/csd_gcd_step.sv
// ----------------------------------------------------------------------------
// csd_gcd_step
// One step of a binary gcd with an odd first operand.
// ----------------------------------------------------------------------------
module csd_gcd_step #(
    parameter int unsigned WIDTH = 17
) (
    input  logic [WIDTH-1:0] a_in,
    input  logic [WIDTH-1:0] b_in,
    output logic [WIDTH-1:0] a_out,
    output logic [WIDTH-1:0] b_out
);

    // a stays odd, so twos in b never belong to the gcd
    always_comb begin
        a_out = a_in;
        b_out = b_in;
        if (!b_in[0]) begin
            b_out = b_in >> 1;
        end else if (a_in > b_in) begin
            a_out = b_in;
            b_out = a_in - b_in;
        end else begin
            b_out = b_in - a_in;
        end
    end

endmodule

FILE: rtl/core/coprime_stride_tile_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// coprime_stride_tile_dispatcher_unit
// Hands out tiles in a pseudo-random permutation (k * stride) mod total.
//
//   channel | ports                                          | role
//   --------+------------------------------------------------+------------------
//   s_      | s_valid s_ready s_total/done/active/ready_tiles | tile request in
//   m_      | m_valid m_ready m_tile_index m_exhausted       | tile result out
//
// An exhausted request goes straight to ST_FINISH to have its result registered.
// A dispatch spends COUNT_WIDTH+1 steps reducing the stride, then up to
// 2*COUNT_WIDTH steps of modular shift-and-add, all on the one shared
// modular adder. The first dispatch after reset adds 32 steps for seed mod
// total plus the coprime search on the gcd step unit.
// Reset is synchronous, active low. s_ready is high only while idle; a new
// item is taken while a finished result waits on m_.
// ----------------------------------------------------------------------------
module coprime_stride_tile_dispatcher_unit #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [COUNT_WIDTH-1:0]       s_total_tiles,
    input  logic [COUNT_WIDTH-1:0]       s_done_tiles,
    input  logic [COUNT_WIDTH-1:0]       s_active_tiles,
    input  logic [COUNT_WIDTH-1:0]       s_ready_tiles,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [csd_pkg::TILE_W-1:0]   m_tile_index,
    output logic                         m_exhausted
);

    import csd_pkg::*;

    localparam int unsigned W  = COUNT_WIDTH;
    localparam int unsigned SW = COUNT_WIDTH + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_MOD,
        ST_GCD,
        ST_PREP,
        ST_STRIDE_MOD,
        ST_DOUBLE,
        ST_ADD,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [SEED_W-1:0]    seed_reg, seed_next;
    logic [SW-1:0]        stride_reg, stride_next;
    logic                 stride_valid_reg, stride_valid_next;
    logic [W-1:0]         pos_reg, pos_next;
    logic [W-1:0]         total_reg, total_next;
    logic [W-1:0]         rem_reg, rem_next;
    logic [W-1:0]         smod_reg, smod_next;
    logic [SEED_W-1:0]    bits_reg, bits_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic [SW-1:0]        cand_reg, cand_next;
    logic [SW-1:0]        ga_reg, ga_next;
    logic [SW-1:0]        gb_reg, gb_next;
    logic [TILE_W-1:0]    res_tile_reg, res_tile_next;
    logic                 res_exh_reg, res_exh_next;
    logic                 m_valid_reg, m_valid_next;
    logic [TILE_W-1:0]    m_tile_reg, m_tile_next;
    logic                 m_exh_reg, m_exh_next;

    logic                 s_fire;
    logic [W+1:0]         busy_sum;
    logic                 req_exhausted;
    logic [W-1:0]         ma_b;
    logic                 ma_cin;
    logic [W-1:0]         ma_sum;
    logic [SW-1:0]        ga_step;
    logic [SW-1:0]        gb_step;
    logic [SW-1:0]        cand_odd;
    logic [SW-1:0]        cand_bump;

    assign s_ready      = (state_reg == ST_IDLE);
    assign s_fire       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_tile_index = m_tile_reg;
    assign m_exhausted  = m_exh_reg;

    // Exact sum of the busy counts against the frame size
    assign busy_sum      = {2'b00, s_done_tiles} + {2'b00, s_active_tiles}
                         + {2'b00, s_ready_tiles};
    assign req_exhausted = (busy_sum >= {2'b00, s_total_tiles});

    // Shared modular adder operand select
    assign ma_b   = (state_reg == ST_ADD) ? smod_reg : rem_reg;
    assign ma_cin = ((state_reg == ST_SEED_MOD) || (state_reg == ST_STRIDE_MOD))
                  ? bits_reg[SEED_W-1] : 1'b0;

    csd_modadd #(
        .WIDTH (W)
    ) u_modadd (
        .a       (rem_reg),
        .b       (ma_b),
        .cin     (ma_cin),
        .modulus (total_reg),
        .result  (ma_sum)
    );

    csd_gcd_step #(
        .WIDTH (SW)
    ) u_gcd_step (
        .a_in  (ga_reg),
        .b_in  (gb_reg),
        .a_out (ga_step),
        .b_out (gb_step)
    );

    // Force the reduced seed odd, and the next odd candidate
    assign cand_odd  = {1'b0, ma_sum | {{(W-1){1'b0}}, 1'b1}};
    assign cand_bump = cand_reg + SW'(2);

    // Sequencer next-state logic
    always_comb begin
        state_next        = state_reg;
        seed_next         = seed_reg;
        stride_next       = stride_reg;
        stride_valid_next = stride_valid_reg;
        pos_next          = pos_reg;
        total_next        = total_reg;
        rem_next          = rem_reg;
        smod_next         = smod_reg;
        bits_next         = bits_reg;
        cnt_next          = cnt_reg;
        cand_next         = cand_reg;
        ga_next           = ga_reg;
        gb_next           = gb_reg;
        res_tile_next     = res_tile_reg;
        res_exh_next      = res_exh_reg;
        m_valid_next      = m_valid_reg;
        m_tile_next       = m_tile_reg;
        m_exh_next        = m_exh_reg;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    total_next = s_total_tiles;
                    rem_next   = '0;
                    if (req_exhausted) begin
                        res_tile_next = '0;
                        res_exh_next  = 1'b1;
                        state_next    = ST_FINISH;
                    end else if (!stride_valid_reg) begin
                        seed_next  = xorshift_next(seed_reg);
                        bits_next  = xorshift_next(seed_reg);
                        cnt_next   = STEP_W'(SEED_W);
                        state_next = ST_SEED_MOD;
                    end else begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_SEED_MOD: begin
                rem_next  = ma_sum;
                bits_next = bits_reg << 1;
                cnt_next  = cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    cand_next  = cand_odd;
                    ga_next    = cand_odd;
                    gb_next    = {1'b0, total_reg};
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                if (gb_reg == '0) begin
                    if (ga_reg == SW'(1)) begin
                        stride_next       = cand_reg;
                        stride_valid_next = 1'b1;
                        state_next        = ST_PREP;
                    end else begin
                        cand_next = cand_bump;
                        ga_next   = cand_bump;
                        gb_next   = {1'b0, total_reg};
                    end
                end else begin
                    ga_next = ga_step;
                    gb_next = gb_step;
                end
            end
            ST_PREP: begin
                // Wrap the position, then reduce the stride mod total
                if (pos_reg >= total_reg) begin
                    pos_next = '0;
                end
                rem_next   = '0;
                bits_next  = SEED_W'(stride_reg) << (SEED_W - SW);
                cnt_next   = STEP_W'(SW);
                state_next = ST_STRIDE_MOD;
            end
            ST_STRIDE_MOD: begin
                rem_next  = ma_sum;
                bits_next = bits_reg << 1;
                cnt_next  = cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    smod_next  = ma_sum;
                    rem_next   = '0;
                    bits_next  = SEED_W'(pos_reg) << (SEED_W - W);
                    cnt_next   = STEP_W'(W);
                    state_next = ST_DOUBLE;
                end
            end
            ST_DOUBLE: begin
                rem_next = ma_sum;
                if (bits_reg[SEED_W-1]) begin
                    state_next = ST_ADD;
                end else if (cnt_reg == STEP_W'(1)) begin
                    res_tile_next = TILE_W'(ma_sum);
                    res_exh_next  = 1'b0;
                    pos_next      = pos_reg + W'(1);
                    state_next    = ST_FINISH;
                end else begin
                    cnt_next  = cnt_reg - STEP_W'(1);
                    bits_next = bits_reg << 1;
                end
            end
            ST_ADD: begin
                rem_next = ma_sum;
                if (cnt_reg == STEP_W'(1)) begin
                    res_tile_next = TILE_W'(ma_sum);
                    res_exh_next  = 1'b0;
                    pos_next      = pos_reg + W'(1);
                    state_next    = ST_FINISH;
                end else begin
                    cnt_next   = cnt_reg - STEP_W'(1);
                    bits_next  = bits_reg << 1;
                    state_next = ST_DOUBLE;
                end
            end
            ST_FINISH: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_tile_next  = res_tile_reg;
                    m_exh_next   = res_exh_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            seed_reg         <= SEED_RESET;
            stride_reg       <= '0;
            stride_valid_reg <= 1'b0;
            pos_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            seed_reg         <= seed_next;
            stride_reg       <= stride_next;
            stride_valid_reg <= stride_valid_next;
            pos_reg          <= pos_next;
            m_valid_reg      <= m_valid_next;
        end
        total_reg    <= total_next;
        rem_reg      <= rem_next;
        smod_reg     <= smod_next;
        bits_reg     <= bits_next;
        cnt_reg      <= cnt_next;
        cand_reg     <= cand_next;
        ga_reg       <= ga_next;
        gb_reg       <= gb_next;
        res_tile_reg <= res_tile_next;
        res_exh_reg  <= res_exh_next;
        m_tile_reg   <= m_tile_next;
        m_exh_reg    <= m_exh_next;
    end

`ifndef SYNTHESIS
    // An exhausted result never carries a tile
    a_exh_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_exhausted |-> m_tile_index == '0)
        else $error("exhausted result with nonzero tile index");

    // A chosen stride is odd
    a_stride_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        stride_valid_reg |-> stride_reg[0])
        else $error("stride is even");

    // Once chosen, the stride is kept until reset
    a_stride_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        stride_valid_reg |=> stride_valid_reg && $stable(stride_reg))
        else $error("stride changed after selection");

    // The seed only moves when a first dispatch is taken
    a_seed_once: assert property (@(posedge aclk) disable iff (!aresetn)
        stride_valid_reg |=> $stable(seed_reg))
        else $error("seed advanced after stride selection");
`endif

endmodule
